[design/bcps_pkg.sv]
// Shared constants and types of the B-spline camera path stepper.
package bcps_pkg;

    localparam int POINT_COUNT_DEF   = 64;
    localparam int FRACTION_BITS_DEF = 16;

    // Rounded blend values before the divide by six, and the divider length.
    localparam int T_BITS   = 28;
    localparam int BIAS_EXP = 26;
    localparam int DIV_BITS = 29;

    // One sixth scaled by 2^32 and rounded up; the product shifted down by 32 is
    // the exact quotient for any dividend below 2^31.
    localparam logic [31:0] RECIP6 = 32'd715827883;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam int LANES = 5;
    localparam int LANE_VIEW = 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_U2,
        ST_U3,
        ST_WT,
        ST_RD,
        ST_PREP,
        ST_DIV,
        ST_ADV,
        ST_OUT
    } state_t;

endpackage

[design/bspline_camera_path_stepper.sv]
// Top level of the B-spline camera path stepper: point table, spline blend and path stepping.
// Load, restart and unused transactions are completed on acceptance; s_tready is high only while idle.
// A tick computes the weights, reads five table entries, rounds the blend values, forms the speed
// reciprocals by bitwise division and steps the path before its result is offered.
// A tick that finds a stop ahead skips the reciprocals. A stalled result adds wait.
// Reset (aresetn low, synchronous) clears key, fraction and the result valid flag; tables are not.
module bspline_camera_path_stepper #(
    parameter int POINT_COUNT   = bcps_pkg::POINT_COUNT_DEF,
    parameter int FRACTION_BITS = bcps_pkg::FRACTION_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // write_index[5:0], point_x[21:6], point_y[37:22], point_z[53:38], point_roll[61:54],
    // point_view_angle[77:62], frame_count[92:78], stop_flag[93], zero fill [95:94]
    input  logic [95:0]  s_tdata,
    // command[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x[23:0], pos_y[47:24], pos_z[71:48], roll_out[87:72], view_angle_out[103:88]
    output logic [103:0] m_tdata,
    // done_res
    output logic         m_tlast
);
    import bcps_pkg::*;

    localparam int KW = $clog2(POINT_COUNT);
    localparam int FB = FRACTION_BITS;
    localparam int WW = FB + 4;
    localparam int AW = FB + 24;
    localparam logic [FB:0] SCALE = (FB+1)'(1) << FB;

    // Table memories: {z, y, x} and {roll, view, frames, stop}.
    logic [47:0] pos_mem  [POINT_COUNT];
    logic [39:0] attr_mem [POINT_COUNT];
    logic [47:0] pos_rd_reg;
    logic [39:0] attr_rd_reg;

    state_t state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [KW-1:0] key_reg, key_next;
    logic [FB-1:0] frac_reg, frac_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [103:0] m_tdata_reg, m_tdata_next;
    logic m_tlast_reg, m_tlast_next;

    logic [FB-1:0] u2_reg, u3_reg;
    logic signed [WW-1:0] w_reg [4];
    logic signed [AW-1:0] acc_reg [LANES];
    logic [4:0] stop_reg;
    logic rd_ok_reg;
    logic [14:0] fr1_reg, fr2_reg;
    logic [DIV_BITS-1:0] dq_reg [LANES];
    logic [DIV_BITS-1:0] sq_reg [2];
    logic [14:0] srem_reg [2];
    logic [FB:0] s1_reg;
    logic signed [2*FB+2:0] prod_reg;

    logic s_acc;
    logic [1:0] cmd;
    logic [KW+5:0] wi_ext;
    logic [KW+2:0] rd_idx;
    logic rd_ok;
    logic [2:0] slot;
    logic commit;

    assign s_acc  = s_tvalid && s_tready;
    assign cmd    = s_tuser;
    assign wi_ext = {{KW{1'b0}}, s_tdata[5:0]};
    assign rd_idx = {3'b000, key_reg} + (KW+3)'(cnt_reg[2:0]);
    assign rd_ok  = rd_idx < (KW+3)'(POINT_COUNT);
    assign slot   = cnt_reg[2:0] - 3'd1;

    always_ff @(posedge aclk) begin
        if (s_acc && cmd == CMD_LOAD && wi_ext < (KW+6)'(POINT_COUNT)) begin
            pos_mem[wi_ext[KW-1:0]]  <= s_tdata[53:6];
            attr_mem[wi_ext[KW-1:0]] <= {s_tdata[61:54], s_tdata[77:62], s_tdata[92:78],
                                         s_tdata[93]};
        end
        pos_rd_reg  <= pos_mem[rd_idx[KW-1:0]];
        attr_rd_reg <= attr_mem[rd_idx[KW-1:0]];
    end

    // Weight selected for the point now arriving from memory, and the five lane values.
    logic signed [WW-1:0] w_sel;
    logic signed [16:0] p_lane [LANES];
    always_comb begin
        w_sel = w_reg[slot[1:0]];
        if (rd_ok_reg) begin
            p_lane[0] = {pos_rd_reg[15], pos_rd_reg[15:0]};
            p_lane[1] = {pos_rd_reg[31], pos_rd_reg[31:16]};
            p_lane[2] = {pos_rd_reg[47], pos_rd_reg[47:32]};
            p_lane[3] = {{9{attr_rd_reg[39]}}, attr_rd_reg[39:32]};
            p_lane[4] = {1'b0, attr_rd_reg[31:16]};
        end else begin
            for (int l = 0; l < LANES; l++) p_lane[l] = '0;
        end
    end

    // Weights from the fraction powers.
    logic signed [WW-1:0] su, su2, su3, ss;
    assign su  = signed'(WW'(frac_reg));
    assign su2 = signed'(WW'(u2_reg));
    assign su3 = signed'(WW'(u3_reg));
    assign ss  = signed'(WW'(SCALE));

    // Rounded, biased blend value for the divide by six.
    function automatic logic [DIV_BITS-1:0] prep_val(logic signed [AW-1:0] acc, logic gain);
        logic signed [AW+7:0] ng;
        logic signed [AW+7:0] sh;
        logic signed [T_BITS-1:0] t;
        begin
            ng = gain ? {acc, 8'h00} : {{8{acc[AW-1]}}, acc};
            sh = (ng + (AW+8)'(3 * (64'(1) << FB))) >>> FB;
            t  = sh[T_BITS-1:0];
            prep_val = DIV_BITS'(DIV_BITS'(signed'(t)) + DIV_BITS'(6 * (64'(1) << BIAS_EXP)));
        end
    endfunction

    // Quotient by six through multiplication with the scaled reciprocal.
    function automatic logic [DIV_BITS-1:0] div6(logic [DIV_BITS-1:0] v);
        logic [DIV_BITS+31:0] p;
        begin
            p = (DIV_BITS+32)'(v) * (DIV_BITS+32)'(RECIP6);
            div6 = DIV_BITS'(p >> 32);
        end
    endfunction

    function automatic logic signed [DIV_BITS:0] unbias(logic [DIV_BITS-1:0] q);
        unbias = signed'({1'b0, q}) - (DIV_BITS+1)'(64'(1) << BIAS_EXP);
    endfunction

    // Datapath registers, advanced by the sequencer state.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_U2: begin
                u2_reg <= FB'((2*FB)'(frac_reg) * (2*FB)'(frac_reg) >> FB);
            end
            ST_U3: begin
                u3_reg <= FB'((2*FB)'(u2_reg) * (2*FB)'(frac_reg) >> FB);
            end
            ST_WT: begin
                w_reg[0] <= WW'(ss - 3 * su + 3 * su2 - su3);
                w_reg[1] <= WW'(3 * su3 - 6 * su2 + 4 * ss);
                w_reg[2] <= WW'(-3 * su3 + 3 * su2 + 3 * su + ss);
                w_reg[3] <= su3;
                for (int l = 0; l < LANES; l++) acc_reg[l] <= '0;
            end
            ST_RD: begin
                rd_ok_reg <= rd_ok;
                if (cnt_reg != 6'd0) begin
                    stop_reg[slot] <= !rd_ok_reg || attr_rd_reg[0];
                    if (slot == 3'd1) fr1_reg <= rd_ok_reg ? attr_rd_reg[15:1] : 15'd0;
                    if (slot == 3'd2) fr2_reg <= rd_ok_reg ? attr_rd_reg[15:1] : 15'd0;
                    if (slot < 3'd4) begin
                        for (int l = 0; l < LANES; l++)
                            acc_reg[l] <= acc_reg[l] + AW'(w_sel * p_lane[l]);
                    end
                end
            end
            ST_PREP: begin
                for (int l = 0; l < LANES; l++) begin
                    dq_reg[l] <= prep_val(acc_reg[l], l != LANE_VIEW);
                end
                for (int j = 0; j < 2; j++) begin
                    sq_reg[j]   <= DIV_BITS'(SCALE);
                    srem_reg[j] <= '0;
                end
            end
            ST_DIV: begin
                if (cnt_reg == 6'd0) begin
                    for (int l = 0; l < LANES; l++) dq_reg[l] <= div6(dq_reg[l]);
                end
                for (int j = 0; j < 2; j++) begin
                    logic [15:0] r;
                    logic [15:0] d;
                    d = {1'b0, (j == 0) ? fr1_reg : fr2_reg};
                    r = {srem_reg[j], sq_reg[j][DIV_BITS-1]};
                    if (r >= d) begin
                        srem_reg[j] <= 15'(r - d);
                        sq_reg[j]   <= {sq_reg[j][DIV_BITS-2:0], 1'b1};
                    end else begin
                        srem_reg[j] <= r[14:0];
                        sq_reg[j]   <= {sq_reg[j][DIV_BITS-2:0], 1'b0};
                    end
                end
            end
            ST_ADV: begin
                logic [FB:0] s1, s2;
                logic signed [FB+1:0] diff;
                s1 = (fr1_reg == 15'd0) ? '0 : sq_reg[0][FB:0];
                s2 = (fr2_reg == 15'd0) ? '0 : sq_reg[1][FB:0];
                diff = signed'({1'b0, s2}) - signed'({1'b0, s1});
                s1_reg   <= s1;
                prod_reg <= (2*FB+3)'(signed'({1'b0, frac_reg})) * (2*FB+3)'(diff);
            end
            default: begin
            end
        endcase
    end

    // Result assembly, saturation and path stepping.
    logic stop_ahead;
    logic signed [DIV_BITS:0] r_lane [LANES];
    logic [23:0] o_pos [3];
    logic [15:0] o_roll, o_view;
    logic signed [FB+3:0] adv, nf;
    logic step;
    always_comb begin
        stop_ahead = stop_reg[0] || stop_reg[1] || stop_reg[2];
        for (int l = 0; l < LANES; l++) r_lane[l] = unbias(dq_reg[l]);
        for (int l = 0; l < 3; l++) begin
            if (r_lane[l] < -(DIV_BITS+1)'(32'sd8388608))
                o_pos[l] = 24'h800000;
            else if (r_lane[l] > (DIV_BITS+1)'(32'sd8388607))
                o_pos[l] = 24'h7FFFFF;
            else
                o_pos[l] = r_lane[l][23:0];
        end
        if (r_lane[3] < -(DIV_BITS+1)'(32'sd32768))
            o_roll = 16'h8000;
        else if (r_lane[3] > (DIV_BITS+1)'(32'sd32767))
            o_roll = 16'h7FFF;
        else
            o_roll = r_lane[3][15:0];
        if (r_lane[4] < (DIV_BITS+1)'(0))
            o_view = 16'h0000;
        else if (r_lane[4] > (DIV_BITS+1)'(32'sd65535))
            o_view = 16'hFFFF;
        else
            o_view = r_lane[4][15:0];

        adv = (FB+4)'(prod_reg >>> FB) + signed'((FB+4)'(s1_reg));
        if (adv < 0) adv = '0;
        nf = signed'((FB+4)'(frac_reg)) + adv;
        step = nf >= signed'((FB+4)'(SCALE));
        if (step) nf = nf - signed'((FB+4)'(SCALE));
        if (nf >= signed'((FB+4)'(SCALE))) nf = signed'((FB+4)'(SCALE)) - (FB+4)'(1);
    end

    assign commit = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        key_next      = key_reg;
        frac_next     = frac_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        s_tready      = state_reg == ST_IDLE;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (cmd == CMD_TICK) begin
                        state_next = ST_U2;
                    end else if (cmd == CMD_RESTART) begin
                        key_next  = '0;
                        frac_next = '0;
                    end
                end
            end
            ST_U2: state_next = ST_U3;
            ST_U3: state_next = ST_WT;
            ST_WT: begin
                state_next = ST_RD;
                cnt_next   = '0;
            end
            ST_RD: begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd5) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cnt_next   = '0;
                state_next = stop_ahead ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_BITS - 1)) begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV: state_next = ST_OUT;
            ST_OUT: begin
                if (commit) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                    if (stop_ahead) begin
                        m_tdata_next = '0;
                        m_tlast_next = 1'b1;
                    end else begin
                        m_tdata_next = {o_view, o_roll, o_pos[2], o_pos[1], o_pos[0]};
                        frac_next    = nf[FB-1:0];
                        m_tlast_next = 1'b0;
                        if (step) begin
                            // The new fourth point is the old fifth one.
                            if (stop_reg[4]) begin
                                key_next     = '0;
                                m_tlast_next = 1'b1;
                            end else begin
                                key_next = key_reg + KW'(1);
                            end
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            key_reg      <= '0;
            frac_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            key_reg      <= key_next;
            frac_reg     <= frac_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
